/* design/smks_pkg.sv */
`default_nettype none

package smks_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int USED_W      = IDX_W + 1;
    localparam int VAL_W       = 32;
    localparam int COPY_W      = 32;
    localparam int CNT_W       = 40;
    // running total never exceeds TABLE_DEPTH * (2^CNT_W - 1)
    localparam int SUM_W       = CNT_W + IDX_W;

    typedef struct packed {
        logic [VAL_W-1:0] val;
        logic [CNT_W-1:0] cnt;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } tbl_wr_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_FIND   = 6'b000010,
        ST_INS    = 6'b000100,
        ST_PLACE  = 6'b001000,
        ST_QRY    = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

endpackage

`default_nettype wire

/* design/smks_table.sv */
`default_nettype none

module smks_table (
    input  wire logic                    clk,
    input  wire smks_pkg::tbl_wr_t       wr,
    input  wire logic [smks_pkg::IDX_W-1:0] rd_addr,
    output smks_pkg::entry_t             rd_data
);
    import smks_pkg::*;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* design/sorted_multiset_kth_select_unit.sv */
// Sorted multiset with k-th smallest query.
//
// Input channel (in_valid / in_stall): each transaction adds `copies` copies
// of signed `value`. A new value is inserted in ascending order; a known one
// has its 40-bit count raised, saturating. On a full table a new value is
// dropped and the batch overflow flag is set.
// Output channel (out_valid / out_stall): one transaction per input marked
// `last`, carrying kth_value, found and overflow. The batch then restarts.
// Config channel (cfg_valid / cfg_ready): writes rank_k; always ready, and
// meant to be written only while the block is idle.
//
// Operation: the search walks down from the top entry through one read port
// with registered read data, one entry per cycle. A new value needs a second
// walk that moves larger entries up. `last` adds a rank walk up from the
// bottom entry; in_stall stays high.
// The result waits in an output register; if out_stall holds it, the block
// waits before presenting the next one.
// Reset: empties the table (entry count cleared, no memory sweep), clears
// the overflow flag and sets rank_k to 1.
`default_nettype none

module sorted_multiset_kth_select_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [smks_pkg::CNT_W-1:0]     cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic signed [smks_pkg::VAL_W-1:0] value,
    input  wire logic [smks_pkg::COPY_W-1:0]    copies,
    input  wire logic                           last,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [smks_pkg::VAL_W-1:0]   kth_value,
    output logic                                found,
    output logic                                overflow
);
    import smks_pkg::*;

    state_t                 state_reg, state_next;
    logic [USED_W-1:0]      used_reg, used_next;
    logic                   ovf_reg, ovf_next;
    logic [CNT_W-1:0]       rank_reg, rank_next;
    logic [USED_W-1:0]      cnt_reg, cnt_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]       place_idx_reg, place_idx_next;
    logic [SUM_W-1:0]       total_reg, total_next;
    logic                   res_found_reg, res_found_next;
    logic [VAL_W-1:0]       res_val_reg, res_val_next;
    logic                   out_valid_reg, out_valid_next;

    logic [VAL_W-1:0]       val_reg;
    logic [COPY_W-1:0]      copies_reg;
    logic                   last_reg;
    logic [VAL_W-1:0]       kth_value_reg;
    logic                   found_reg;
    logic                   overflow_reg;

    tbl_wr_t                wr;
    logic [IDX_W-1:0]       rd_addr;
    entry_t                 rd_data;

    logic                   accept;
    logic                   full;
    logic                   ins_done;
    logic                   out_load;
    logic [IDX_W-1:0]       idx_up;
    logic [CNT_W:0]         cnt_sum;
    logic [CNT_W-1:0]       cnt_sat;
    logic [SUM_W-1:0]       run_sum;
    logic                   q_lt;
    logic                   q_eq;

    smks_table u_table (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign full      = (used_reg == USED_W'(TABLE_DEPTH));
    assign idx_up    = rd_idx_reg + 1'b1;
    assign cnt_sum   = {1'b0, rd_data.cnt} + (CNT_W+1)'(copies_reg);
    assign cnt_sat   = cnt_sum[CNT_W] ? {CNT_W{1'b1}} : cnt_sum[CNT_W-1:0];
    assign run_sum   = total_reg + SUM_W'(rd_data.cnt);
    assign q_lt      = ($signed(rd_data.val) < $signed(val_reg));
    assign q_eq      = (rd_data.val == val_reg);
    assign out_load  = (state_reg == ST_RESULT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        ovf_next       = ovf_reg;
        rank_next      = rank_reg;
        cnt_next       = cnt_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        place_idx_next = place_idx_reg;
        total_next     = total_reg;
        res_found_next = res_found_reg;
        res_val_next   = res_val_reg;
        out_valid_next = out_valid_reg;
        wr             = '0;
        rd_addr        = '0;
        ins_done       = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            rank_next = cfg_data;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next       = used_reg;
                    place_idx_next = '0;
                    state_next     = (used_reg == '0) ? ST_PLACE : ST_FIND;
                end
            end

            ST_FIND:
            begin
                // search only, walking down from the top; nothing moves yet
                if (cnt_reg != '0)
                begin
                    rd_addr     = IDX_W'(cnt_reg - 1'b1);
                    rd_vld_next = 1'b1;
                    rd_idx_next = IDX_W'(cnt_reg - 1'b1);
                    cnt_next    = cnt_reg - 1'b1;
                end
                if (rd_vld_reg)
                begin
                    if (q_eq)
                    begin
                        wr.en       = 1'b1;
                        wr.addr     = rd_idx_reg;
                        wr.data.val = rd_data.val;
                        wr.data.cnt = cnt_sat;
                        rd_vld_next = 1'b0;
                        ins_done    = 1'b1;
                    end
                    else if (q_lt || rd_idx_reg == '0)
                    begin
                        // value is new
                        rd_vld_next = 1'b0;
                        if (full)
                        begin
                            ovf_next = 1'b1;
                            ins_done = 1'b1;
                        end
                        else
                        begin
                            cnt_next   = used_reg;
                            state_next = ST_INS;
                        end
                    end
                end
            end

            ST_INS:
            begin
                // value is new and fits: reads run one entry ahead, walking
                // down from the top, each larger entry moves up one slot
                if (cnt_reg != '0)
                begin
                    rd_addr     = IDX_W'(cnt_reg - 1'b1);
                    rd_vld_next = 1'b1;
                    rd_idx_next = IDX_W'(cnt_reg - 1'b1);
                    cnt_next    = cnt_reg - 1'b1;
                end
                if (rd_vld_reg)
                begin
                    if (q_lt)
                    begin
                        wr.en       = 1'b1;
                        wr.addr     = idx_up;
                        wr.data.val = val_reg;
                        wr.data.cnt = CNT_W'(copies_reg);
                        used_next   = used_reg + 1'b1;
                        rd_vld_next = 1'b0;
                        ins_done    = 1'b1;
                    end
                    else
                    begin
                        wr.en   = 1'b1;
                        wr.addr = idx_up;
                        wr.data = rd_data;
                        if (rd_idx_reg == '0)
                        begin
                            place_idx_next = '0;
                            state_next     = ST_PLACE;
                        end
                    end
                end
            end

            ST_PLACE:
            begin
                if (full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    wr.en       = 1'b1;
                    wr.addr     = place_idx_reg;
                    wr.data.val = val_reg;
                    wr.data.cnt = CNT_W'(copies_reg);
                    used_next   = used_reg + 1'b1;
                end
                ins_done = 1'b1;
            end

            ST_QRY:
            begin
                if (rank_reg == '0 || used_reg == '0)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    if (cnt_reg < used_reg)
                    begin
                        rd_addr     = cnt_reg[IDX_W-1:0];
                        rd_vld_next = 1'b1;
                        rd_idx_next = cnt_reg[IDX_W-1:0];
                        cnt_next    = cnt_reg + 1'b1;
                    end
                    if (rd_vld_reg)
                    begin
                        total_next = run_sum;
                        if (run_sum >= SUM_W'(rank_reg))
                        begin
                            res_found_next = 1'b1;
                            res_val_next   = rd_data.val;
                            rd_vld_next    = 1'b0;
                            state_next     = ST_RESULT;
                        end
                        else if (({1'b0, rd_idx_reg} + 1'b1) == used_reg)
                        begin
                            rd_vld_next = 1'b0;
                            state_next  = ST_RESULT;
                        end
                    end
                end
            end

            ST_RESULT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    used_next      = '0;
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (ins_done)
        begin
            if (last_reg)
            begin
                cnt_next       = '0;
                total_next     = '0;
                res_found_next = 1'b0;
                res_val_next   = '0;
                state_next     = ST_QRY;
            end
            else
            begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            ovf_reg       <= 1'b0;
            rank_reg      <= CNT_W'(1);
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            ovf_reg       <= ovf_next;
            rank_reg      <= rank_next;
            cnt_reg       <= cnt_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_idx_next;
        place_idx_reg <= place_idx_next;
        total_reg     <= total_next;
        res_found_reg <= res_found_next;
        res_val_reg   <= res_val_next;
        if (accept)
        begin
            val_reg    <= value;
            copies_reg <= copies;
            last_reg   <= last;
        end
        if (out_load)
        begin
            kth_value_reg <= res_val_reg;
            found_reg     <= res_found_reg;
            overflow_reg  <= ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign kth_value = kth_value_reg;
    assign found     = found_reg;
    assign overflow  = overflow_reg;

endmodule

`default_nettype wire

/* design/smks_checker.sv */
`default_nettype none

module smks_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] kth_value,
    input wire logic        found
);

    // one item at a time: the block goes busy right after taking one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while previous item still in work");

    // a result cannot appear the cycle right after an item is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !$rose(out_valid))
        else $error("result appeared too early after input transaction");

    // a miss reports zero
    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (kth_value == '0))
        else $error("kth_value nonzero with found low");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(kth_value) && $stable(found)))
        else $error("stalled result changed");

endmodule

bind sorted_multiset_kth_select_unit smks_checker u_smks_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kth_value (kth_value),
    .found     (found)
);

`default_nettype wire

/* sim/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import smks_pkg::*;

    localparam int          RUN_LIMIT = 1_000_000;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic signed [VAL_W-1:0] kth_value;
        logic                    found;
        logic                    overflow;
    } kth_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CNT_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic signed [VAL_W-1:0] value;
    logic [COPY_W-1:0] copies;
    logic last;
    logic out_valid;
    logic out_stall;
    logic signed [VAL_W-1:0] kth_value;
    logic found;
    logic overflow;

    // shadow of the block's table and rank register
    logic signed [VAL_W-1:0] tbl_value [TABLE_DEPTH];
    logic [CNT_W-1:0]        tbl_count [TABLE_DEPTH];
    int                      tbl_used;
    bit                      tbl_dropped;
    logic [CNT_W-1:0]        rank_k_model;

    kth_result_t kth_pending[$];

    int idle_pct;
    int stall_pct;
    int errors;
    int items_sent;
    int results_checked;
    int found_seen;
    int overflow_seen;
    int rank_writes;
    int cycles;

    sorted_multiset_kth_select_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .copies    (copies),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kth_value (kth_value),
        .found     (found),
        .overflow  (overflow)
    );

    always #6 clk = ~clk;

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("%0t: run limit of %0d cycles reached", $time, RUN_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic void multiset_add(input logic signed [VAL_W-1:0] v,
                                         input logic [COPY_W-1:0] c);
        int pos;
        int i;
        logic [CNT_W:0] sum;
        pos = 0;
        while (pos < tbl_used && tbl_value[pos] < v)
            pos++;
        if (pos < tbl_used && tbl_value[pos] == v)
        begin
            sum = tbl_count[pos] + c;
            tbl_count[pos] = (sum > COUNT_MAX) ? COUNT_MAX : sum[CNT_W-1:0];
        end
        else if (tbl_used >= TABLE_DEPTH)
        begin
            tbl_dropped = 1'b1;
        end
        else
        begin
            for (i = tbl_used; i > pos; i--)
            begin
                tbl_value[i] = tbl_value[i-1];
                tbl_count[i] = tbl_count[i-1];
            end
            tbl_value[pos] = v;
            tbl_count[pos] = c;
            tbl_used++;
        end
    endfunction

    // rank walk at end of batch; also empties the shadow table
    function automatic kth_result_t close_batch();
        kth_result_t r;
        logic [63:0] total;
        int i;
        r.kth_value = '0;
        r.found = 1'b0;
        r.overflow = tbl_dropped;
        total = '0;
        if (rank_k_model != '0)
        begin
            for (i = 0; i < tbl_used; i++)
            begin
                total += tbl_count[i];
                if (total >= rank_k_model)
                begin
                    r.kth_value = tbl_value[i];
                    r.found = 1'b1;
                    break;
                end
            end
        end
        tbl_used = 0;
        tbl_dropped = 1'b0;
        return r;
    endfunction

    always @(posedge clk)
    begin
        kth_result_t exp_r;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (kth_pending.size() == 0)
            begin
                $display("%0t: result with none pending, got kth_value %0d found %0b overflow %0b",
                         $time, kth_value, found, overflow);
                errors++;
            end
            else
            begin
                exp_r = kth_pending.pop_front();
                results_checked++;
                if (found === 1'b1)
                    found_seen++;
                if (overflow === 1'b1)
                    overflow_seen++;
                if (kth_value !== exp_r.kth_value)
                begin
                    $display("%0t: kth_value mismatch, expected %0d, got %0d",
                             $time, exp_r.kth_value, kth_value);
                    errors++;
                end
                if (found !== exp_r.found)
                begin
                    $display("%0t: found mismatch, expected %0b, got %0b",
                             $time, exp_r.found, found);
                    errors++;
                end
                if (overflow !== exp_r.overflow)
                begin
                    $display("%0t: overflow mismatch, expected %0b, got %0b",
                             $time, exp_r.overflow, overflow);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(input logic signed [VAL_W-1:0] v, input logic [COPY_W-1:0] c,
                             input logic l);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        value <= v;
        copies <= c;
        last <= l;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        items_sent++;
        multiset_add(v, c);
        if (l)
            kth_pending.push_back(close_batch());
    endtask

    // drop valid and let every pending result come back
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (kth_pending.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_rank(input logic [CNT_W-1:0] k);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= k;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        rank_k_model = k;
        rank_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return '0;
            3: return -1;
            4, 5: return $signed($urandom_range(40)) - 20;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] pick_rank();
        logic [CNT_W-1:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(5))
            0: return '0;
            1: return $urandom_range(1, 6);
            2: return $urandom_range(1, 60);
            3: return COUNT_MAX;
            default: return r >> $urandom_range(CNT_W - 1);
        endcase
    endfunction

    // rank 1 out of reset; a zero-copy entry never takes the rank
    task automatic test_reset_rank();
        send_item(-5, 0, 1'b0);
        send_item(7, 2, 1'b0);
        send_item(3, 1, 1'b1);
        send_item(9, 0, 1'b1);
    endtask

    task automatic test_field_extremes();
        write_rank(3);
        send_item(32'sh8000_0000, 32'hFFFF_FFFF, 1'b0);
        send_item(32'sh7FFF_FFFF, 1, 1'b0);
        send_item(0, 32'h5555_5555, 1'b0);
        send_item(-1, 32'hAAAA_AAAA, 1'b0);
        send_item(32'sh7FFF_FFFF, 3, 1'b1);
        write_rank(COUNT_MAX);
        send_item(32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_item(32'sh8000_0000, 0, 1'b1);
        write_rank(0);
        send_item(12, 100, 1'b0);
        send_item(-12, 1, 1'b1);
    endtask

    // rank equal to the total, one past it, and one inside it
    task automatic test_rank_edges();
        write_rank(6);
        send_item(10, 2, 1'b0);
        send_item(-3, 3, 1'b0);
        send_item(10, 1, 1'b1);
        write_rank(7);
        send_item(10, 2, 1'b0);
        send_item(-3, 3, 1'b0);
        send_item(10, 1, 1'b1);
        write_rank(4);
        send_item(10, 2, 1'b0);
        send_item(-3, 3, 1'b0);
        send_item(10, 1, 1'b1);
    endtask

    task automatic test_count_saturation();
        int i;
        write_rank(COUNT_MAX);
        send_item(-200, 0, 1'b0);
        for (i = 0; i < 258; i++)
            send_item(-100, 32'hFFFF_FFFF, 1'b0);
        send_item(50, 1, 1'b1);
        send_item(3, 32'hFFFF_FFFF, 1'b0);
        send_item(3, 32'hFFFF_FFFF, 1'b1);
    endtask

    // ascending fill keeps each insert at the top of the table
    task automatic test_table_full();
        int i;
        logic signed [VAL_W-1:0] base;
        base = 32'sh8000_0000;
        write_rank(TABLE_DEPTH + 5);
        for (i = 0; i < TABLE_DEPTH; i++)
            send_item(base + i * 32'sd4194304, 1, 1'b0);
        send_item(base, 5, 1'b0);
        send_item(base + 32'sd1, 1, 1'b0);
        send_item(32'sh7FFF_FFFF, 7, 1'b0);
        send_item(1, 2, 1'b1);
        send_item(1, 1, 1'b1);
    endtask

    task automatic test_random_traffic(input int gap_pct, input int hold_pct, input int n_items);
        logic signed [VAL_W-1:0] pool [8];
        logic signed [VAL_W-1:0] v;
        logic [COPY_W-1:0] c;
        int sent;
        int batch_len;
        int pool_n;
        int i;
        bit wide_copies;
        wait_idle();
        idle_pct = gap_pct;
        stall_pct = hold_pct;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(3) == 0)
                write_rank(pick_rank());
            batch_len = ($urandom_range(9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 25);
            pool_n = $urandom_range(1, 8);
            for (i = 0; i < pool_n; i++)
                pool[i] = pick_value();
            wide_copies = ($urandom_range(2) == 0);
            for (i = 0; i < batch_len; i++)
            begin
                v = ($urandom_range(4) == 0) ? pick_value() : pool[$urandom_range(pool_n - 1)];
                c = wide_copies ? $urandom : $urandom_range(4);
                send_item(v, c, i == batch_len - 1);
            end
            sent += batch_len;
        end
    endtask

    initial
    begin
        int waited;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        value = '0;
        copies = '0;
        last = 1'b0;
        out_stall = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        errors = 0;
        items_sent = 0;
        results_checked = 0;
        found_seen = 0;
        overflow_seen = 0;
        rank_writes = 0;
        cycles = 0;
        tbl_used = 0;
        tbl_dropped = 1'b0;
        rank_k_model = 1;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_rank();
        test_field_extremes();
        test_rank_edges();
        test_count_saturation();
        test_table_full();
        test_random_traffic(0, 0, 145);
        test_random_traffic(69, 0, 145);
        test_random_traffic(0, 69, 145);
        test_random_traffic(15, 15, 145);

        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (kth_pending.size() != 0 && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (2 * TABLE_DEPTH + 16) @(negedge clk);
        if (kth_pending.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, kth_pending.size());
            errors += kth_pending.size();
        end

        $display("Sent %0d items in directed, full-table, saturation and random batches",
                 items_sent);
        $display("Checked %0d rank results (%0d found, %0d overflow) over %0d rank settings",
                 results_checked, found_seen, overflow_seen, rank_writes);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
